/* rtl/core/assert_macros.svh */
// Assertion macros used by the parser's entry queue.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define DOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that the consequent holds whenever the antecedent holds.
`define DOP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DOP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/dop_pkg.sv */
// Types and constants of the DHCP options parser.
// No dependencies; every other file of the block but the two interfaces and the macros imports it.
package dop_pkg;

  localparam int unsigned DopQueueDepth = 4;
  localparam logic [7:0] FieldMaxReset  = 8'd64;

  // Option codes.
  localparam logic [7:0] OptPad      = 8'd0;
  localparam logic [7:0] OptMask     = 8'd1;
  localparam logic [7:0] OptRouter   = 8'd3;
  localparam logic [7:0] OptDns      = 8'd6;
  localparam logic [7:0] OptHost     = 8'd12;
  localparam logic [7:0] OptDomain   = 8'd15;
  localparam logic [7:0] OptReqIp    = 8'd50;
  localparam logic [7:0] OptLease    = 8'd51;
  localparam logic [7:0] OptOverload = 8'd52;
  localparam logic [7:0] OptMsgType  = 8'd53;
  localparam logic [7:0] OptServer   = 8'd54;
  localparam logic [7:0] OptParam    = 8'd55;
  localparam logic [7:0] OptMaxSize  = 8'd57;
  localparam logic [7:0] OptCid      = 8'd61;
  localparam logic [7:0] OptEnd      = 8'd255;

  typedef enum logic [3:0] {
    KindMask     = 4'd0,
    KindRouter   = 4'd1,
    KindDns      = 4'd2,
    KindDomain   = 4'd3,
    KindMsgType  = 4'd4,
    KindMaxSize  = 4'd5,
    KindHost     = 4'd6,
    KindReqIp    = 4'd7,
    KindLease    = 4'd8,
    KindServer   = 4'd9,
    KindCidType  = 4'd10,
    KindCidByte  = 4'd11,
    KindParam    = 4'd12,
    KindStatus   = 4'd13
  } dop_kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadLen  = 2'd1,
    StTooLong = 2'd2,
    StNoEnd   = 2'd3
  } dop_status_e;

  typedef enum logic [2:0] {
    PhCode = 3'b001,
    PhLen  = 3'b010,
    PhVal  = 3'b100
  } dop_phase_e;

  // What one accepted word leaves for the output side: an optional item
  // and an optional closing status.
  typedef struct packed {
    logic        item_vld;
    dop_kind_e   kind;
    logic [7:0]  index;
    logic [31:0] value;
    logic        stat_vld;
    dop_status_e status;
  } dop_entry_t;

endpackage

/* rtl/core/dop_in_if.sv */
// Input channel of the DHCP options parser: one raw byte per word.
// Stand-alone interface, no package dependency.
interface dop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/core/dop_out_if.sv */
// Output channel of the DHCP options parser: one decoded item per word.
// Stand-alone interface, no package dependency.
interface dop_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  item_kind;
  logic [7:0]  item_index;
  logic [31:0] item_value;
  logic [1:0]  parse_status;
  logic        last_result;

  modport source (output valid, output item_kind, output item_index, output item_value,
                  output parse_status, output last_result, input ready);
  modport sink   (input valid, input item_kind, input item_index, input item_value,
                  input parse_status, input last_result, output ready);
endinterface

/* rtl/core/dop_front.sv */
// Front end of the DHCP options parser: walks the code/length/value bytes,
// checks lengths and builds queue entries. Uses dop_pkg and dop_in_if.
module dop_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  dop_in_if.sink            in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output dop_pkg::dop_entry_t entry_o
);
  import dop_pkg::*;

  logic [7:0]  field_max_q;
  dop_phase_e  phase_q, phase_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  off_q, off_d;
  logic [31:0] acc_q, acc_d;
  dop_status_e err_q, err_d;
  logic        end_q, end_d;
  logic        accept;
  logic [7:0]  b;
  dop_status_e len_st;
  dop_entry_t  entry;

  function automatic dop_status_e check_len(input logic [7:0] code, input logic [7:0] len,
                                            input logic [7:0] fmax);
    dop_status_e st;
    st = StOk;
    case (code)
      OptMask, OptReqIp, OptLease, OptServer: st = (len == 8'd4) ? StOk : StBadLen;
      OptMsgType, OptOverload:                st = (len == 8'd1) ? StOk : StBadLen;
      OptMaxSize:                             st = (len == 8'd2) ? StOk : StBadLen;
      OptRouter, OptDns: begin
        if (len >= 8'd4 && len[1:0] != 2'b00) st = StBadLen;
        else if (len > fmax)                  st = StTooLong;
      end
      OptHost, OptDomain, OptParam: begin
        if (len == 8'd0)      st = StBadLen;
        else if (len > fmax)  st = StTooLong;
      end
      OptCid: begin
        if (len < 8'd2)       st = StBadLen;
        else if (len > fmax)  st = StTooLong;
      end
      default: st = StOk;
    endcase
    return st;
  endfunction

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign len_st     = check_len(code_q, b, field_max_q);

  always_comb begin
    phase_d        = phase_q;
    code_d         = code_q;
    left_d         = left_q;
    off_d          = off_q;
    acc_d          = acc_q;
    err_d          = err_q;
    end_d          = end_q;
    entry.item_vld = 1'b0;
    entry.kind     = KindStatus;
    entry.index    = 8'd0;
    entry.value    = 32'd0;
    entry.stat_vld = 1'b0;
    entry.status   = StOk;

    if (err_q == StOk && !end_q) begin
      case (phase_q)
        PhCode: begin
          if (b == OptEnd) begin
            end_d = 1'b1;
          end else if (b != OptPad) begin
            code_d  = b;
            phase_d = PhLen;
          end
        end
        PhLen: begin
          if (len_st != StOk) begin
            err_d = len_st;
          end else begin
            left_d  = b;
            off_d   = 8'd0;
            acc_d   = 32'd0;
            phase_d = (b != 8'd0) ? PhVal : PhCode;
          end
        end
        PhVal: begin
          acc_d = {acc_q[23:0], b};
          case (code_q)
            OptMask: begin
              entry.item_vld = (off_q == 8'd3);
              entry.kind     = KindMask;
              entry.value    = acc_d;
            end
            OptReqIp: begin
              entry.item_vld = (off_q == 8'd3);
              entry.kind     = KindReqIp;
              entry.value    = acc_d;
            end
            OptLease: begin
              entry.item_vld = (off_q == 8'd3);
              entry.kind     = KindLease;
              entry.value    = acc_d;
            end
            OptServer: begin
              entry.item_vld = (off_q == 8'd3);
              entry.kind     = KindServer;
              entry.value    = acc_d;
            end
            OptRouter: begin
              entry.item_vld = (off_q[1:0] == 2'b11);
              entry.kind     = KindRouter;
              entry.index    = {2'b00, off_q[7:2]};
              entry.value    = acc_d;
            end
            OptDns: begin
              entry.item_vld = (off_q[1:0] == 2'b11);
              entry.kind     = KindDns;
              entry.index    = {2'b00, off_q[7:2]};
              entry.value    = acc_d;
            end
            OptMsgType: begin
              entry.item_vld = 1'b1;
              entry.kind     = KindMsgType;
              entry.value    = {24'd0, b};
            end
            OptMaxSize: begin
              entry.item_vld = (off_q == 8'd1);
              entry.kind     = KindMaxSize;
              entry.value    = {16'd0, acc_d[15:0]};
            end
            OptDomain: begin
              entry.item_vld = 1'b1;
              entry.kind     = KindDomain;
              entry.index    = off_q;
              entry.value    = {24'd0, b};
            end
            OptHost: begin
              entry.item_vld = 1'b1;
              entry.kind     = KindHost;
              entry.index    = off_q;
              entry.value    = {24'd0, b};
            end
            OptParam: begin
              entry.item_vld = 1'b1;
              entry.kind     = KindParam;
              entry.index    = off_q;
              entry.value    = {24'd0, b};
            end
            OptCid: begin
              entry.item_vld = 1'b1;
              entry.kind     = (off_q == 8'd0) ? KindCidType : KindCidByte;
              entry.index    = (off_q == 8'd0) ? 8'd0 : off_q - 8'd1;
              entry.value    = {24'd0, b};
            end
            default: entry.item_vld = 1'b0;
          endcase
          off_d  = off_q + 8'd1;
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) phase_d = PhCode;
        end
        default: phase_d = PhCode;
      endcase
    end

    // The status reflects this byte's own processing, then the message state clears.
    if (in_i.last_byte) begin
      entry.stat_vld = 1'b1;
      if (err_d != StOk) entry.status = err_d;
      else if (end_d)    entry.status = StOk;
      else               entry.status = StNoEnd;
      phase_d = PhCode;
      code_d  = 8'd0;
      left_d  = 8'd0;
      off_d   = 8'd0;
      acc_d   = 32'd0;
      err_d   = StOk;
      end_d   = 1'b0;
    end
  end

  assign push_o  = accept && (entry.item_vld || entry.stat_vld);
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_max_q <= FieldMaxReset;
      phase_q     <= PhCode;
      code_q      <= 8'd0;
      left_q      <= 8'd0;
      off_q       <= 8'd0;
      acc_q       <= 32'd0;
      err_q       <= StOk;
      end_q       <= 1'b0;
    end else begin
      if (cfg_we_i) field_max_q <= cfg_data_i;
      if (accept) begin
        phase_q <= phase_d;
        code_q  <= code_d;
        left_q  <= left_d;
        off_q   <= off_d;
        acc_q   <= acc_d;
        err_q   <= err_d;
        end_q   <= end_d;
      end
    end
  end

endmodule

/* rtl/core/dop_queue.sv */
// Short queue of parser entries between the front and back ends.
// Uses dop_pkg for the entry type and assert_macros.svh for checks.
`include "assert_macros.svh"

module dop_queue #(
  parameter int unsigned Depth = dop_pkg::DopQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dop_pkg::dop_entry_t entry_i,
  input  logic                pop_i,
  output dop_pkg::dop_entry_t entry_o,
  output logic                full_o,
  output logic                empty_o
);
  import dop_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dop_entry_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i)      count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

  `DOP_ASSERT_IMP(a_no_push_full, push_i, !full_o, "queue written while full")
  `DOP_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o, "queue read while empty")
  `DOP_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + CntW'(1), "queue count lost a push")

endmodule

/* rtl/core/dop_back.sv */
// Back end of the DHCP options parser: drains queue entries into the
// output register, an item word first and then its status. Uses dop_pkg.
module dop_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  dop_pkg::dop_entry_t entry_i,
  output logic                pop_o,
  dop_out_if.source           out_o
);
  import dop_pkg::*;

  logic        valid_q, valid_d;
  logic        pend_q, pend_d;
  dop_status_e pend_st_q, pend_st_d;
  logic        load;
  logic [3:0]  kind_q, kind_d;
  logic [7:0]  index_q, index_d;
  logic [31:0] value_q, value_d;
  logic [1:0]  status_q, status_d;
  logic        last_q, last_d;
  logic        slot_free;

  assign slot_free = !valid_q || out_o.ready;
  assign pop_o     = slot_free && !pend_q && !q_empty_i;

  always_comb begin
    valid_d   = valid_q;
    pend_d    = pend_q;
    pend_st_d = pend_st_q;
    load      = 1'b0;
    kind_d    = KindStatus;
    index_d   = 8'd0;
    value_d   = 32'd0;
    status_d  = StOk;
    last_d    = 1'b1;
    if (slot_free) begin
      valid_d = 1'b0;
      if (pend_q) begin
        // A status held back behind the item of the same word.
        valid_d  = 1'b1;
        load     = 1'b1;
        pend_d   = 1'b0;
        status_d = pend_st_q;
      end else if (!q_empty_i) begin
        valid_d = 1'b1;
        load    = 1'b1;
        if (entry_i.item_vld) begin
          kind_d    = entry_i.kind;
          index_d   = entry_i.index;
          value_d   = entry_i.value;
          last_d    = 1'b0;
          pend_d    = entry_i.stat_vld;
          pend_st_d = entry_i.status;
        end else begin
          status_d = entry_i.status;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      pend_q    <= 1'b0;
      pend_st_q <= StOk;
    end else begin
      valid_q   <= valid_d;
      pend_q    <= pend_d;
      pend_st_q <= pend_st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      index_q  <= index_d;
      value_q  <= value_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.item_kind    = kind_q;
  assign out_o.item_index   = index_q;
  assign out_o.item_value   = value_q;
  assign out_o.parse_status = status_q;
  assign out_o.last_result  = last_q;

endmodule

/* rtl/core/dhcp_option_parser_unit.sv */
// Top level of the DHCP options parser: front end, entry queue, back end.
// Uses dop_pkg, dop_in_if, dop_out_if, dop_front, dop_queue and dop_back.
// Throughput: one option byte per cycle while the queue is not full; a last
// byte that also yields an item produces two words, drained through the queue
// at one word per cycle while the output is ready. The output is registered.
// Reset (asynchronous, active low): field_max returns to 64, parser expects a code.
module dhcp_option_parser_unit #(
  parameter int unsigned QueueDepth = dop_pkg::DopQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  dop_in_if.sink     in_i,
  dop_out_if.source  out_o
);
  import dop_pkg::*;

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  dop_entry_t push_entry;
  dop_entry_t pop_entry;

  dop_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  dop_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dop_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .entry_i   (pop_entry),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

/* tb/dop_parse_checker.sv */
// Scoreboard for the DHCP options parser: watches both channels and the config port.
// Keeps its own option walker, queues the words it predicts and compares them in order.
// Depends on dop_pkg, dop_in_if and dop_out_if.
module dop_parse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  dop_in_if           in_mon,
  dop_out_if          out_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  import dop_pkg::*;

  typedef struct packed {
    dop_kind_e   kind;
    logic [7:0]  index;
    logic [31:0] value;
    dop_status_e status;
    logic        last;
  } parse_item_t;

  parse_item_t expect_q[$];
  int unsigned bad_cnt;

  // Shadow copy of the parser state and the field_max register.
  logic [7:0]  fmax;
  dop_phase_e  ph;
  logic [7:0]  opt;
  logic [7:0]  left;
  logic [7:0]  off;
  logic [31:0] acc;
  dop_status_e err;
  logic        seen_end;

  function automatic dop_status_e len_verdict(logic [7:0] code, logic [7:0] len);
    case (code)
      OptMask, OptReqIp, OptLease, OptServer: return (len == 8'd4) ? StOk : StBadLen;
      OptMsgType, OptOverload: return (len == 8'd1) ? StOk : StBadLen;
      OptMaxSize: return (len == 8'd2) ? StOk : StBadLen;
      OptRouter, OptDns: begin
        if (len >= 8'd4 && len[1:0] != 2'd0) return StBadLen;
        return (len > fmax) ? StTooLong : StOk;
      end
      OptHost, OptDomain, OptParam: begin
        if (len < 8'd1) return StBadLen;
        return (len > fmax) ? StTooLong : StOk;
      end
      OptCid: begin
        if (len < 8'd2) return StBadLen;
        return (len > fmax) ? StTooLong : StOk;
      end
      default: return StOk;
    endcase
  endfunction

  task automatic push_item(input dop_kind_e kind, input logic [7:0] idx,
                           input logic [31:0] val, input dop_status_e st, input logic lst);
    parse_item_t w;
    w.kind   = kind;
    w.index  = idx;
    w.value  = val;
    w.status = st;
    w.last   = lst;
    expect_q.push_back(w);
  endtask

  task automatic clear_msg();
    ph       = PhCode;
    opt      = 8'd0;
    left     = 8'd0;
    off      = 8'd0;
    acc      = 32'd0;
    err      = StOk;
    seen_end = 1'b0;
  endtask

  // One value byte: addresses and times are built big-endian, strings pass through.
  task automatic take_value(input logic [7:0] b);
    acc = {acc[23:0], b};
    case (opt)
      OptMask:    if (off == 8'd3) push_item(KindMask, 8'd0, acc, StOk, 1'b0);
      OptReqIp:   if (off == 8'd3) push_item(KindReqIp, 8'd0, acc, StOk, 1'b0);
      OptLease:   if (off == 8'd3) push_item(KindLease, 8'd0, acc, StOk, 1'b0);
      OptServer:  if (off == 8'd3) push_item(KindServer, 8'd0, acc, StOk, 1'b0);
      OptRouter:  if (off[1:0] == 2'd3) push_item(KindRouter, off >> 2, acc, StOk, 1'b0);
      OptDns:     if (off[1:0] == 2'd3) push_item(KindDns, off >> 2, acc, StOk, 1'b0);
      OptMsgType: push_item(KindMsgType, 8'd0, {24'd0, b}, StOk, 1'b0);
      OptMaxSize: if (off == 8'd1) push_item(KindMaxSize, 8'd0, {16'd0, acc[15:0]}, StOk, 1'b0);
      OptDomain:  push_item(KindDomain, off, {24'd0, b}, StOk, 1'b0);
      OptHost:    push_item(KindHost, off, {24'd0, b}, StOk, 1'b0);
      OptParam:   push_item(KindParam, off, {24'd0, b}, StOk, 1'b0);
      OptCid: begin
        if (off == 8'd0) push_item(KindCidType, 8'd0, {24'd0, b}, StOk, 1'b0);
        else push_item(KindCidByte, off - 8'd1, {24'd0, b}, StOk, 1'b0);
      end
      default: ;
    endcase
    off  = off + 8'd1;
    left = left - 8'd1;
    if (left == 8'd0) ph = PhCode;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic lst);
    dop_status_e verdict;
    if (err == StOk && !seen_end) begin
      case (ph)
        PhCode: begin
          if (b == OptEnd) seen_end = 1'b1;
          else if (b != OptPad) begin
            opt = b;
            ph  = PhLen;
          end
        end
        PhLen: begin
          verdict = len_verdict(opt, b);
          if (verdict != StOk) err = verdict;
          else begin
            left = b;
            off  = 8'd0;
            acc  = 32'd0;
            ph   = (b != 8'd0) ? PhVal : PhCode;
          end
        end
        default: take_value(b);
      endcase
    end
    // The closing status follows whatever the last byte itself produced.
    if (lst) begin
      if (err != StOk) verdict = err;
      else if (seen_end) verdict = StOk;
      else verdict = StNoEnd;
      push_item(KindStatus, 8'd0, 32'd0, verdict, 1'b1);
      clear_msg();
    end
  endtask

  task automatic check_word();
    parse_item_t want;
    if (expect_q.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("unexpected word: kind %0d idx %0d val %08h st %0d last %0d",
                 out_mon.item_kind, out_mon.item_index, out_mon.item_value,
                 out_mon.parse_status, out_mon.last_result);
      return;
    end
    want = expect_q.pop_front();
    if (out_mon.item_kind !== want.kind || out_mon.item_index !== want.index ||
        out_mon.item_value !== want.value || out_mon.parse_status !== want.status ||
        out_mon.last_result !== want.last) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("wrong word: expected kind %0d idx %0d val %08h st %0d last %0d, %s",
                 want.kind, want.index, want.value, want.status, want.last,
                 $sformatf("got kind %0d idx %0d val %08h st %0d last %0d",
                           out_mon.item_kind, out_mon.item_index, out_mon.item_value,
                           out_mon.parse_status, out_mon.last_result));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmax = FieldMaxReset;
      clear_msg();
      expect_q.delete();
      bad_cnt = 0;
      mismatch_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) fmax = cfg_data_i;
      if (in_mon.valid && in_mon.ready) predict_byte(in_mon.data_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) check_word();
      mismatch_cnt_o <= bad_cnt;
      pending_o <= expect_q.size();
    end
  end

endmodule

/* tb/tb_dhcp_option_parser_unit.sv */
// Top of the DHCP options parser testbench: clock, reset, option stimulus and verdict.
// Drives dhcp_option_parser_unit and leaves all checking to dop_parse_checker.
// Depends on dop_pkg, dop_in_if, dop_out_if, dop_parse_checker and the block itself.
module tb_dhcp_option_parser_unit;
  import dop_pkg::*;

  typedef enum logic [1:0] {RdyAlways, RdyCoin, RdySparse, RdyPeriodic} rdy_mode_e;

  localparam logic [7:0] KnownOpts [13] = '{OptMask, OptRouter, OptDns, OptHost, OptDomain,
                                            OptReqIp, OptLease, OptOverload, OptMsgType,
                                            OptServer, OptParam, OptMaxSize, OptCid};
  localparam int unsigned PhaseBytes = 106;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_data_i;
  int unsigned mismatch_cnt;
  int unsigned pending;

  dop_in_if  in_ch();
  dop_out_if out_ch();

  dhcp_option_parser_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  dop_parse_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("dhcp_option_parser_unit: mismatch");
    $finish;
  end

  // Receiver: holds one ready pattern for a random stretch, then picks another.
  rdy_mode_e   rdy_mode = RdyAlways;
  int unsigned rdy_left = 0;
  logic [7:0]  rdy_tick = 8'd0;

  always @(posedge clk_i) begin
    rdy_tick <= rdy_tick + 8'd1;
    if (rdy_left == 0) begin
      rdy_left <= $urandom_range(16, 96);
      rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      RdyAlways:   out_ch.ready <= 1'b1;
      RdyCoin:     out_ch.ready <= 1'($urandom_range(0, 1));
      RdySparse:   out_ch.ready <= ($urandom_range(0, 3) == 0);
      RdyPeriodic: out_ch.ready <= rdy_tick[2];
      default:     out_ch.ready <= 1'b1;
    endcase
  end

  int unsigned bytes_sent;
  int unsigned burst_left;
  logic [7:0]  msg_q[$];
  logic [7:0]  fm_now = FieldMaxReset;
  logic [7:0]  fm_plan [8];

  // Sender: bursts of random length, each mostly preceded by a short gap.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    bytes_sent += msg_q.size();
    msg_q.delete();
  endtask

  // Waits until every predicted word has been taken, plus the pipeline depth.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_field_max(input logic [7:0] v);
    wait_quiet();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    fm_now     = v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 13) return KnownOpts[r];
    if (r == 13) return OptPad;
    return 8'($urandom_range(62, 254));
  endfunction

  // A length that the option's rule accepts under the current field_max, where one exists.
  // Mostly short; now and then as long as field_max allows.
  function automatic logic [7:0] good_len(logic [7:0] code);
    int unsigned cap;
    cap = ($urandom_range(0, 15) == 0) ? fm_now : ((fm_now < 12) ? fm_now : 12);
    case (code)
      OptMask, OptReqIp, OptLease, OptServer: return 8'd4;
      OptMsgType, OptOverload: return 8'd1;
      OptMaxSize: return 8'd2;
      OptRouter, OptDns: begin
        if (cap < 4 || $urandom_range(0, 4) == 0)
          return 8'($urandom_range(0, (cap < 3) ? cap : 3));
        return 8'(4 * $urandom_range(1, cap / 4));
      end
      OptHost, OptDomain, OptParam: return 8'((cap < 1) ? 1 : $urandom_range(1, cap));
      OptCid: return 8'((cap < 2) ? 2 : $urandom_range(2, cap));
      default: return 8'($urandom_range(0, 6));
    endcase
  endfunction

  task automatic add_option(input bit broken);
    logic [7:0] code;
    logic [7:0] len;
    code = pick_code();
    if (code == OptPad) begin
      msg_q.push_back(OptPad);
      return;
    end
    len = broken ? 8'($urandom_range(0, 255)) : good_len(code);
    msg_q.push_back(code);
    msg_q.push_back(len);
    repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_message();
    int unsigned shape;
    logic [7:0]  code;
    logic [7:0]  len;
    shape = $urandom_range(0, 15);
    if (shape <= 10) begin
      // Mostly well-formed options closed by END, sometimes with trailing bytes.
      repeat ($urandom_range(1, 5)) add_option($urandom_range(0, 15) == 0);
      msg_q.push_back(OptEnd);
      repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else if (shape <= 12) begin
      // The area stops inside an option.
      repeat ($urandom_range(0, 3)) add_option(1'b0);
      code = pick_code();
      if (code == OptPad) code = OptMask;
      msg_q.push_back(code);
      if ($urandom_range(0, 3) != 0) begin
        len = good_len(code);
        msg_q.push_back(len);
        repeat ($urandom_range(0, (len == 0) ? 0 : len - 1))
          msg_q.push_back(8'($urandom_range(0, 255)));
      end
    end else if (shape == 13) begin
      repeat ($urandom_range(1, 4)) add_option(1'b0);
    end else if (shape == 14) begin
      repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) add_option(1'b0);
      add_option(1'b1);
      repeat ($urandom_range(0, 4)) msg_q.push_back(8'($urandom_range(0, 255)));
    end
    if (msg_q.size() == 0) msg_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = 8'd0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    bytes_sent      = 0;
    burst_left      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pad, message type, overload and an unknown empty option, END, then ignored bytes.
    msg_q = '{OptPad, OptMsgType, 8'd1, 8'hFF, OptOverload, 8'd1, 8'd3, 8'd200, 8'd0,
              OptEnd, 8'h07, 8'h00};
    send_message();
    // Bad mask length; the rest is ignored.
    msg_q = '{OptMask, 8'd3, 8'd9, 8'hFF};
    send_message();
    // The last byte both completes a domain option and closes without END.
    msg_q = '{OptDomain, 8'd2, 8'h61, 8'h62};
    send_message();
    msg_q = '{OptEnd};
    send_message();
    // Router list longer than field_max.
    msg_q = '{OptRouter, 8'd68, 8'd0};
    send_message();

    fm_plan = '{8'd0, 8'd1, 8'd255, 8'd2, 8'($urandom_range(3, 254)), 8'd4,
                8'($urandom_range(3, 254)), FieldMaxReset};
    foreach (fm_plan[p]) begin
      int unsigned goal;
      write_field_max(fm_plan[p]);
      goal = bytes_sent + PhaseBytes;
      while (bytes_sent < goal) begin
        build_message();
        send_message();
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("dhcp_option_parser_unit: match");
    end else begin
      $display("dhcp_option_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/dop_pkg.sv
rtl/core/dop_in_if.sv
rtl/core/dop_out_if.sv
rtl/core/dop_front.sv
rtl/core/dop_queue.sv
rtl/core/dop_back.sv
rtl/core/dhcp_option_parser_unit.sv
tb/dop_parse_checker.sv
tb/tb_dhcp_option_parser_unit.sv
